// ===== src/jls_pkg.sv =====
`default_nettype none

package jls_pkg;

  localparam int DefaultMaxRows = 64;

  // Restoring division produces one quotient bit a cycle
  localparam int DivSteps = 47;

  localparam logic [46:0] ThresholdReset = 47'd4294967;
  localparam logic [15:0] LimitReset     = 16'd3000;
  localparam logic [6:0]  RowsReset      = 7'd64;

  localparam logic signed [47:0] V48Max = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] V48Min = 48'sh8000_0000_0000;
  localparam logic [62:0]        SumMax = {63{1'b1}};
  localparam logic [48:0]        OneQ32 = 49'h1_0000_0000;

  typedef enum logic [1:0] {
    CMD_MATRIX = 2'd0,
    CMD_RHS    = 2'd1,
    CMD_GUESS  = 2'd2,
    CMD_SOLVE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_ZERO_DIAG = 2'd2
  } solve_status_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_LIMIT     = 2'd1,
    REG_ROWS      = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DIAG,
    B_DIAG_WAIT,
    B_MAC,
    B_DRAIN,
    B_DIV_INIT,
    B_DIV,
    B_UPDATE,
    B_DIST,
    B_DIST_WAIT,
    B_EMIT,
    B_EMIT_WAIT
  } back_state_t;

  typedef struct packed {
    cmd_t               command;
    logic [5:0]         row_index;
    logic [5:0]         column_index;
    logic signed [47:0] entry_value;
  } jls_request_t;

  typedef struct packed {
    logic [5:0]         element_index;
    logic signed [47:0] solution_value;
    logic               last_element;
    logic [15:0]        sweeps_done;
    solve_status_t      solve_status;
    logic [62:0]        update_sum;
    logic [62:0]        distance_from_ones;
  } jls_result_t;

  typedef struct packed {
    logic [46:0] threshold;
    logic [15:0] iteration_limit;
    logic [6:0]  rows_in_use;
  } jls_cfg_t;

endpackage

`default_nettype wire

// ===== src/jls_ram.sv =====
`default_nettype none

module jls_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/jls_front.sv =====
`default_nettype none

module jls_front
  import jls_pkg::*;
#(
  parameter int MAX_ROWS = DefaultMaxRows
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire jls_request_t request,
  input  wire logic         done,
  input  wire logic         pop,
  output logic              busy,
  output logic              q_valid,
  output jls_request_t      q_item
);

  localparam logic [6:0] RowLimit = 7'(MAX_ROWS);

  jls_request_t slot [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;
  logic         pending;
  logic         accept;
  logic         keep;
  logic         push;

  always_comb begin
    busy    = (count == 2'd2) || pending;
    accept  = start && !busy;
    // drop loads whose indexes lie outside the store
    keep    = (request.command == CMD_SOLVE) ||
              (({1'b0, request.row_index} < RowLimit) &&
               ((request.command != CMD_MATRIX) ||
                ({1'b0, request.column_index} < RowLimit)));
    push    = accept && keep;
    q_valid = (count != 2'd0);
    q_item  = slot[rptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= 1'b0;
      rptr    <= 1'b0;
      count   <= 2'd0;
      pending <= 1'b0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
      if (accept && request.command == CMD_SOLVE) begin
        pending <= 1'b1;
      end else if (done) begin
        pending <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/jls_back.sv =====
`default_nettype none

module jls_back
  import jls_pkg::*;
#(
  parameter int MAX_ROWS = DefaultMaxRows
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  input  wire jls_request_t q_item,
  input  wire jls_cfg_t     cfg,
  output logic              pop,
  output logic              done,
  output logic              result_strobe,
  output jls_result_t       result
);

  localparam int RowW = $clog2(MAX_ROWS);
  localparam int MatW = 2 * RowW;
  localparam int MatDepth = 1 << MatW;
  localparam int VecDepth = 1 << RowW;
  localparam logic [6:0] RowLimit = 7'(MAX_ROWS);

  back_state_t state, state_next;

  logic [RowW-1:0] idx, row, n_last, j1, e_idx;
  logic            cur;
  logic            v1, v2, dgv, dv, e_last;
  logic            e_valid_q;
  logic            zero_flag, zero_now;
  logic [15:0]     sweep_cnt;
  logic [62:0]     upd, acc, dist_total;
  solve_status_t   status;

  // ram ports
  logic            mat_we, rhs_we, est0_we, est1_we;
  logic [MatW-1:0] mat_waddr, mat_raddr;
  logic [RowW-1:0] vec_waddr, est_waddr;
  logic [31:0]     mat_rdata;
  logic [47:0]     rhs_rdata, est0_rdata, est1_rdata, est_wdata;

  logic signed [31:0] a_rd;
  logic signed [47:0] x_rd;
  logic signed [47:0] b_rd;
  logic signed [23:0] xh;
  logic signed [24:0] xl;
  logic signed [55:0] prod_h;
  logic signed [56:0] prod_l;
  logic signed [63:0] sum;
  logic signed [31:0] diag;
  logic signed [47:0] xi;

  // divider
  logic signed [63:0] resid;
  logic [63:0]        ur;
  logic [31:0]        ud_now;
  logic [31:0]        ud, rem;
  logic [46:0]        dreg, quo;
  logic               dneg, dsat;
  logic [5:0]         dcnt;
  logic [32:0]        trial;
  logic               qbit;
  logic [31:0]        rem_next;

  // update
  logic signed [47:0] dx;
  logic signed [48:0] xsum;
  logic signed [47:0] xnew;
  logic [47:0]        magdx;
  logic [63:0]        acc_sum;
  logic [62:0]        acc_new;
  logic               converged, limit_hit;

  // distance
  logic signed [48:0] diff;
  logic [48:0]        magd;
  logic [63:0]        dist_sum;

  logic [6:0]         rows_cl;

  jls_ram #(.WIDTH(32), .DEPTH(MatDepth)) u_mat (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(q_item.entry_value[31:0]),
    .raddr(mat_raddr), .rdata(mat_rdata)
  );

  jls_ram #(.WIDTH(48), .DEPTH(VecDepth)) u_rhs (
    .clk(clk), .we(rhs_we), .waddr(vec_waddr), .wdata(q_item.entry_value),
    .raddr(row), .rdata(rhs_rdata)
  );

  jls_ram #(.WIDTH(48), .DEPTH(VecDepth)) u_est0 (
    .clk(clk), .we(est0_we), .waddr(est_waddr), .wdata(est_wdata),
    .raddr(idx), .rdata(est0_rdata)
  );

  jls_ram #(.WIDTH(48), .DEPTH(VecDepth)) u_est1 (
    .clk(clk), .we(est1_we), .waddr(est_waddr), .wdata(est_wdata),
    .raddr(idx), .rdata(est1_rdata)
  );

  // datapath combinational
  always_comb begin
    a_rd     = mat_rdata;
    x_rd     = cur ? est1_rdata : est0_rdata;
    b_rd     = rhs_rdata;
    xh       = x_rd[47:24];
    xl       = {1'b0, x_rd[23:0]};
    zero_now = dgv && (mat_rdata == 32'd0);

    resid  = 64'(b_rd) - sum;
    ur     = resid[63] ? 64'(-resid) : 64'(resid);
    ud_now = diag[31] ? 32'(-diag) : 32'(diag);

    trial    = {rem, dreg[46]};
    qbit     = (trial >= {1'b0, ud});
    rem_next = qbit ? 32'(trial - {1'b0, ud}) : trial[31:0];

    if (dsat) begin
      dx = dneg ? V48Min : V48Max;
    end else begin
      dx = dneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end
    xsum = 49'(xi) + 49'(dx);
    if (xsum[48] != xsum[47]) begin
      xnew = xsum[48] ? V48Min : V48Max;
    end else begin
      xnew = xsum[47:0];
    end
    magdx     = dx[47] ? 48'(-dx) : 48'(dx);
    acc_sum   = {1'b0, acc} + 64'(magdx);
    acc_new   = acc_sum[63] ? SumMax : acc_sum[62:0];
    converged = (acc_new <= 63'(cfg.threshold));
    limit_hit = ({1'b0, sweep_cnt} + 17'd1) >= {1'b0, cfg.iteration_limit};

    diff     = 49'(x_rd) - $signed(OneQ32);
    magd     = diff[48] ? 49'(-diff) : 49'(diff);
    dist_sum = {1'b0, dist_total} + 64'(magd);

    if (cfg.rows_in_use == 7'd0) begin
      rows_cl = 7'd1;
    end else if (cfg.rows_in_use > RowLimit) begin
      rows_cl = RowLimit;
    end else begin
      rows_cl = cfg.rows_in_use;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid && q_item.command == CMD_SOLVE) state_next = B_DIAG;
      end
      B_DIAG: begin
        if (idx == n_last) state_next = B_DIAG_WAIT;
      end
      B_DIAG_WAIT: begin
        if (zero_flag || zero_now || cfg.iteration_limit == 16'd0) begin
          state_next = B_EMIT;
        end else begin
          state_next = B_MAC;
        end
      end
      B_MAC: begin
        if (idx == n_last) state_next = B_DRAIN;
      end
      B_DRAIN: begin
        if (!v1 && !v2) state_next = B_DIV_INIT;
      end
      B_DIV_INIT: state_next = B_DIV;
      B_DIV: begin
        if (dcnt == 6'(DivSteps - 1)) state_next = B_UPDATE;
      end
      B_UPDATE: begin
        if (row != n_last) state_next = B_MAC;
        else if (converged) state_next = B_DIST;
        else if (limit_hit) state_next = B_EMIT;
        else state_next = B_MAC;
      end
      B_DIST: begin
        if (idx == n_last) state_next = B_DIST_WAIT;
      end
      B_DIST_WAIT: state_next = B_EMIT;
      B_EMIT: begin
        if (idx == n_last) state_next = B_EMIT_WAIT;
      end
      B_EMIT_WAIT: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs and ram controls
  always_comb begin
    pop       = (state == B_IDLE) && q_valid;
    done      = (state == B_EMIT_WAIT);
    mat_we    = pop && (q_item.command == CMD_MATRIX);
    rhs_we    = pop && (q_item.command == CMD_RHS);
    mat_waddr = {q_item.row_index[RowW-1:0], q_item.column_index[RowW-1:0]};
    vec_waddr = q_item.row_index[RowW-1:0];
    mat_raddr = (state == B_DIAG) ? {idx, idx} : {row, idx};
    if (state == B_UPDATE) begin
      est_waddr = row;
      est_wdata = xnew;
      est0_we   = cur;
      est1_we   = !cur;
    end else begin
      est_waddr = vec_waddr;
      est_wdata = q_item.entry_value;
      est0_we   = pop && (q_item.command == CMD_GUESS) && !cur;
      est1_we   = pop && (q_item.command == CMD_GUESS) && cur;
    end
    result_strobe              = e_valid_q;
    result.element_index       = 6'(e_idx);
    result.solution_value      = x_rd;
    result.last_element        = e_last;
    result.sweeps_done         = sweep_cnt;
    result.solve_status        = status;
    result.update_sum          = upd;
    result.distance_from_ones  = dist_total;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cur       <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      dgv       <= 1'b0;
      dv        <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      state     <= state_next;
      v1        <= (state == B_MAC);
      v2        <= v1;
      dgv       <= (state == B_DIAG);
      dv        <= (state == B_DIST);
      e_valid_q <= (state == B_EMIT);
      if (state == B_UPDATE && row == n_last) begin
        cur <= ~cur;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    j1     <= idx;
    e_idx  <= idx;
    e_last <= (idx == n_last);
    prod_h <= a_rd * xh;
    prod_l <= a_rd * xl;

    if (state == B_DIAG || state == B_MAC || state == B_DIST || state == B_EMIT) begin
      idx <= (idx == n_last) ? '0 : idx + 1'b1;
    end else begin
      idx <= '0;
    end

    if (state == B_IDLE) begin
      n_last     <= RowW'(rows_cl - 7'd1);
      row        <= '0;
      sweep_cnt  <= 16'd0;
      upd        <= '0;
      acc        <= '0;
      dist_total <= '0;
      sum        <= '0;
      zero_flag  <= 1'b0;
      status     <= ST_LIMIT;
    end

    if (zero_now) begin
      zero_flag <= 1'b1;
    end
    if (state == B_DIAG_WAIT && (zero_flag || zero_now)) begin
      status <= ST_ZERO_DIAG;
    end

    // capture diagonal and own estimate as the row streams by
    if (v1 && j1 == row) begin
      diag <= a_rd;
      xi   <= x_rd;
    end
    if (v2) begin
      sum <= sum + 64'(prod_h) + 64'(prod_l >>> 24);
    end

    if (state == B_DIV_INIT) begin
      sum  <= '0;
      ud   <= ud_now;
      dneg <= resid[63] ^ diag[31];
      dsat <= (ur >= 64'({ud_now, 23'd0}));
      rem  <= ur[54:23];
      dreg <= {ur[22:0], 24'd0};
      dcnt <= 6'd0;
    end
    if (state == B_DIV) begin
      rem  <= rem_next;
      dreg <= {dreg[45:0], 1'b0};
      quo  <= {quo[45:0], qbit};
      dcnt <= dcnt + 6'd1;
    end

    if (state == B_UPDATE) begin
      if (row == n_last) begin
        row       <= '0;
        acc       <= '0;
        upd       <= acc_new;
        sweep_cnt <= sweep_cnt + 16'd1;
        status    <= converged ? ST_CONVERGED : ST_LIMIT;
      end else begin
        row <= row + 1'b1;
        acc <= acc_new;
      end
    end

    if (dv) begin
      dist_total <= dist_sum[63] ? SumMax : dist_sum[62:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/jacobi_linear_solver_unit.sv =====
`default_nettype none

// Dense Jacobi solver. Requests load matrix entries (Q8.24), right-hand side
// and starting-guess elements (Q16.32) at one per cycle while busy is low; a
// solve request then holds busy high until the last result has gone out. A
// solve checks the diagonal, runs sweeps in which every row streams its n
// products through one multiplier pair and then a radix-2 restoring divider,
// computes the distance sum after convergence, and finally drives one result
// per element on consecutive cycles with result_strobe high. n is rows_in_use
// clamped to 1..MAX_ROWS. Results cannot be stalled: sample them whenever the
// strobe is high. Write configuration only while busy is low and no load is in
// flight.
module jacobi_linear_solver_unit
  import jls_pkg::*;
#(
  parameter int MAX_ROWS = DefaultMaxRows
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire jls_request_t request,
  output logic              busy,
  input  wire logic         cfg_write,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [46:0]  cfg_data,
  output logic              result_strobe,
  output jls_result_t       result
);

  jls_cfg_t     cfg;
  logic         q_valid;
  jls_request_t q_item;
  logic         pop;
  logic         done;

  // hold configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold       <= ThresholdReset;
      cfg.iteration_limit <= LimitReset;
      cfg.rows_in_use     <= RowsReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg.threshold       <= cfg_data;
        REG_LIMIT:     cfg.iteration_limit <= cfg_data[15:0];
        REG_ROWS:      cfg.rows_in_use     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // front: accept and filter requests into a two-entry queue
  jls_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk(clk), .rst(rst), .start(start), .request(request), .done(done),
    .pop(pop), .busy(busy), .q_valid(q_valid), .q_item(q_item)
  );

  // back: store loads, run the solve, stream results
  jls_back #(.MAX_ROWS(MAX_ROWS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .cfg(cfg),
    .pop(pop), .done(done), .result_strobe(result_strobe), .result(result)
  );

`ifndef SYNTHESIS
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy) else $error("result outside a solve");

  a_solve_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command == CMD_SOLVE) |=> busy)
    else $error("solve request did not raise busy");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last_element) |=> !result_strobe)
    else $error("result after last element");
`endif

endmodule

`default_nettype wire

// ===== tb/jacobi_linear_solver_unit_test.sv =====
`default_nettype none

module jacobi_linear_solver_unit_test;
  import jls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {WORK_REQUEST, WORK_REGISTER, WORK_PACE} work_kind_t;

  typedef struct {
    work_kind_t   kind;
    jls_request_t req;
    reg_index_t   idx;
    logic [46:0]  data;
    int           pct;
  } work_t;

  localparam int WatchdogLimit = 100000;
  localparam int SettleCycles = 8;
  localparam int DrainCycles = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  jls_request_t request = '0;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [46:0] cfg_data = '0;
  logic busy;
  logic result_strobe;
  jls_result_t result;

  jacobi_linear_solver_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_strobe(result_strobe),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the solver: stores, registers and the expected solutions
  logic signed [31:0] coef [64][64];
  longint             rhs_vec [64];
  longint             est_vec [64];
  logic [46:0]        thr_reg = ThresholdReset;
  logic [15:0]        limit_reg = LimitReset;
  logic [6:0]         rows_reg = RowsReset;

  jls_result_t solution_fifo [$];
  work_t       pending_work [$];
  int          errors = 0;
  int          idle_pct = 0;
  int          calm = 0;
  int          quiet = 0;
  int          queued_requests = 0;

  function automatic longint clip48(longint v);
    if (v > longint'(V48Max)) return longint'(V48Max);
    if (v < longint'(V48Min)) return longint'(V48Min);
    return v;
  endfunction

  function automatic longint unsigned abs_of(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  function automatic longint unsigned add_clip(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > 64'(SumMax) || s < a) ? 64'(SumMax) : s;
  endfunction

  // Q8.24 coefficient times Q16.32 estimate, floored back to Q16.32
  function automatic longint scaled_product(longint a, longint x);
    longint xh, xl;
    xh = x >>> 24;
    xl = x - (xh <<< 24);
    return a * xh + ((a * xl) >>> 24);
  endfunction

  // Q16.32 residual over Q8.24 diagonal, truncated toward zero and clipped
  function automatic longint divide_by_diag(longint r, longint d);
    logic neg;
    longint unsigned ur, ud, q, rem, m;
    neg = (r < 0) != (d < 0);
    ur = abs_of(r);
    ud = abs_of(d);
    q = ur / ud;
    rem = ur % ud;
    if (q >= 64'd8388608) return neg ? longint'(V48Min) : longint'(V48Max);
    m = (q << 24) + ((rem << 24) / ud);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic void solve_system();
    int n, sweeps;
    longint unsigned acc, dist_total;
    longint s, dx;
    longint nxt [64];
    solve_status_t st;
    jls_result_t res;
    n = (rows_reg == 0) ? 1 : (rows_reg > 64) ? 64 : int'(rows_reg);
    st = ST_LIMIT;
    sweeps = 0;
    acc = 0;
    dist_total = 0;
    for (int i = 0; i < n; i++) if (coef[i][i] == 0) st = ST_ZERO_DIAG;
    if (st != ST_ZERO_DIAG) begin
      while (sweeps < int'(limit_reg)) begin
        acc = 0;
        for (int i = 0; i < n; i++) begin
          s = 0;
          for (int j = 0; j < n; j++) s += scaled_product(longint'(coef[i][j]), est_vec[j]);
          dx = divide_by_diag(rhs_vec[i] - s, longint'(coef[i][i]));
          nxt[i] = clip48(est_vec[i] + dx);
          acc = add_clip(acc, abs_of(dx));
        end
        for (int i = 0; i < n; i++) est_vec[i] = nxt[i];
        sweeps++;
        if (acc <= 64'(thr_reg)) begin
          st = ST_CONVERGED;
          break;
        end
      end
      if (st == ST_CONVERGED)
        for (int i = 0; i < n; i++)
          dist_total = add_clip(dist_total, abs_of(est_vec[i] - longint'(OneQ32)));
    end
    for (int i = 0; i < n; i++) begin
      res.element_index = 6'(i);
      res.solution_value = 48'(est_vec[i]);
      res.last_element = (i == n - 1);
      res.sweeps_done = 16'(sweeps);
      res.solve_status = st;
      res.update_sum = 63'(acc);
      res.distance_from_ones = 63'(dist_total);
      solution_fifo.push_back(res);
    end
  endfunction

  // Apply one accepted request to the shadow stores
  function automatic void absorb_request(jls_request_t r);
    case (r.command)
      CMD_MATRIX: coef[r.row_index][r.column_index] = r.entry_value[31:0];
      CMD_RHS:    rhs_vec[r.row_index] = longint'(r.entry_value);
      CMD_GUESS:  est_vec[r.row_index] = longint'(r.entry_value);
      CMD_SOLVE:  solve_system();
      default: ;
    endcase
  endfunction

  // Driver: present the head of the work queue; register writes and pace
  // changes hold until the block has drained and settled.
  always @(posedge clk) begin
    logic nxt_start, accepted, nxt_cfg_write;
    jls_request_t nxt_req;
    work_t head;
    accepted = !rst && start && !busy;
    if (accepted) begin
      absorb_request(request);
      void'(pending_work.pop_front());
    end
    if (start || busy || solution_fifo.size() != 0) calm = 0;
    else calm++;
    nxt_start = start && !accepted;
    nxt_req = request;
    nxt_cfg_write = 1'b0;
    if (!rst && !nxt_start && pending_work.size() != 0) begin
      head = pending_work[0];
      case (head.kind)
        WORK_REQUEST: begin
          // Skip a pick-up cycle now and then to idle the sender
          if (accepted || $urandom_range(0, 99) >= idle_pct) begin
            nxt_start = 1'b1;
            nxt_req = head.req;
          end
        end
        WORK_REGISTER: begin
          if (!accepted && calm >= SettleCycles) begin
            nxt_cfg_write = 1'b1;
            cfg_index <= head.idx;
            cfg_data <= head.data;
            case (head.idx)
              REG_THRESHOLD: thr_reg = head.data;
              REG_LIMIT:     limit_reg = head.data[15:0];
              REG_ROWS:      rows_reg = head.data[6:0];
              default: ;
            endcase
            void'(pending_work.pop_front());
          end
        end
        default: begin
          // Pace change doubles as a full drain before the next phase
          if (!accepted && calm >= SettleCycles) begin
            idle_pct = head.pct;
            void'(pending_work.pop_front());
          end
        end
      endcase
    end
    cfg_write <= nxt_cfg_write;
    start <= nxt_start;
    request <= nxt_req;
  end

  task automatic flag_field(string name, longint unsigned exp_v, longint unsigned act_v);
    $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
    errors++;
  endtask

  // Monitor: every strobe carries one solution element; compare field by field
  always @(posedge clk) begin
    jls_result_t exp_r;
    if (!rst && (result_strobe || (start && !busy) || cfg_write)) quiet = 0;
    else quiet++;
    if (quiet >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("Regression FAIL");
      $finish;
    end
    if (!rst && result_strobe) begin
      if (solution_fifo.size() == 0) begin
        $display("%0t: unexpected result: expected none actual %p", $time, result);
        errors++;
      end else begin
        exp_r = solution_fifo.pop_front();
        if (result.element_index !== exp_r.element_index)
          flag_field("element_index", exp_r.element_index, result.element_index);
        if (result.solution_value !== exp_r.solution_value)
          flag_field("solution_value", 48'(exp_r.solution_value), 48'(result.solution_value));
        if (result.last_element !== exp_r.last_element)
          flag_field("last_element", exp_r.last_element, result.last_element);
        if (result.sweeps_done !== exp_r.sweeps_done)
          flag_field("sweeps_done", exp_r.sweeps_done, result.sweeps_done);
        if (result.solve_status !== exp_r.solve_status)
          flag_field("solve_status", exp_r.solve_status, result.solve_status);
        if (result.update_sum !== exp_r.update_sum)
          flag_field("update_sum", exp_r.update_sum, result.update_sum);
        if (result.distance_from_ones !== exp_r.distance_from_ones)
          flag_field("distance_from_ones", exp_r.distance_from_ones, result.distance_from_ones);
      end
    end
  end

  task automatic push_request(cmd_t cmd, int row, int col, logic [47:0] val);
    work_t w;
    w.kind = WORK_REQUEST;
    w.req.command = cmd;
    w.req.row_index = 6'(row);
    w.req.column_index = 6'(col);
    w.req.entry_value = val;
    pending_work.push_back(w);
    queued_requests++;
  endtask

  task automatic push_register(reg_index_t idx, logic [46:0] data);
    work_t w;
    w.kind = WORK_REGISTER;
    w.idx = idx;
    w.data = data;
    pending_work.push_back(w);
  endtask

  task automatic push_pace(int pct);
    work_t w;
    w.kind = WORK_PACE;
    w.pct = pct;
    pending_work.push_back(w);
  endtask

  function automatic longint rand_span(longint span);
    longint unsigned u;
    u = {$urandom(), $urandom()};
    return longint'(u % 64'(2 * span + 1)) - span;
  endfunction

  // System of order n with random content and a heavy diagonal (dominant up to order 4); the unused
  // upper bits of matrix entries get random noise.
  task automatic load_system(int n);
    logic signed [31:0] a;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        if (i == j) begin
          a = 32'($urandom_range(32'h0200_0000, 32'h0800_0000));
          if ($urandom_range(0, 1)) a = -a;
        end else begin
          a = 32'(rand_span(64'h0080_0000));
        end
        push_request(CMD_MATRIX, i, j, {16'($urandom()), a});
      end
    for (int i = 0; i < n; i++)
      push_request(CMD_RHS, i, $urandom_range(0, 63), 48'(rand_span(64'h4_0000_0000)));
    for (int i = 0; i < n; i++)
      push_request(CMD_GUESS, i, $urandom_range(0, 63), 48'(rand_span(64'h4_0000_0000)));
  endtask

  function automatic logic [46:0] pick_threshold();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 47'($urandom_range(0, 32'hFFFF_FFFF));
      2: return ThresholdReset;
      default: return {47{1'b1}};
    endcase
  endfunction

  initial begin
    int n;
    int base;
    int phase;
    int zero_row;
    for (int i = 0; i < 64; i++) begin
      for (int j = 0; j < 64; j++) coef[i][j] = '0;
      rhs_vec[i] = 0;
      est_vec[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: order zero acting as one, with extreme entries
    push_register(REG_ROWS, 47'd0);
    push_register(REG_LIMIT, 47'd2);
    push_request(CMD_MATRIX, 0, 0, {16'hFFFF, 32'h7FFF_FFFF});
    push_request(CMD_RHS, 0, 63, V48Max);
    push_request(CMD_GUESS, 0, 0, V48Min);
    push_request(CMD_SOLVE, 63, 63, {48{1'b1}});
    // Most negative diagonal
    push_request(CMD_MATRIX, 0, 0, {16'h0, 32'h8000_0000});
    push_request(CMD_SOLVE, 0, 0, '0);
    // Zero diagonal entry on the second row
    push_register(REG_ROWS, 47'd2);
    push_request(CMD_MATRIX, 0, 0, 48'h0100_0000);
    push_request(CMD_MATRIX, 0, 1, 48'h0);
    push_request(CMD_MATRIX, 1, 0, 48'h0080_0000);
    push_request(CMD_MATRIX, 1, 1, 48'hFFFF_0000_0000);
    push_request(CMD_RHS, 1, 0, 48'h1_0000_0000);
    push_request(CMD_GUESS, 1, 0, 48'h0);
    push_request(CMD_SOLVE, 0, 0, '0);
    // Iteration limit zero, then loose threshold with the largest limit
    push_request(CMD_MATRIX, 1, 1, 48'h0200_0000);
    push_register(REG_LIMIT, 47'd0);
    push_request(CMD_SOLVE, 0, 0, '0);
    push_register(REG_THRESHOLD, {47{1'b1}});
    push_register(REG_LIMIT, 47'd65535);
    push_request(CMD_SOLVE, 0, 0, '0);
    // Repeated solve with a zero threshold continues from the last estimate
    push_register(REG_THRESHOLD, 47'd0);
    push_register(REG_LIMIT, 47'd3);
    push_request(CMD_SOLVE, 0, 0, '0);
    push_request(CMD_SOLVE, 0, 0, '0);

    // Order above the maximum acts as the maximum; one zero diagonal entry
    // stops the solve after every diagonal has been checked
    push_register(REG_ROWS, 47'd127);
    push_register(REG_LIMIT, 47'd1);
    push_register(REG_THRESHOLD, ThresholdReset);
    zero_row = $urandom_range(2, 63);
    for (int i = 0; i < 64; i++)
      push_request(CMD_MATRIX, i, i, (i == zero_row) ? 48'h0 : 48'h0100_0000);
    for (int i = 0; i < 64; i++)
      push_request(CMD_GUESS, i, 0, 48'(rand_span(64'h4_0000_0000)));
    push_request(CMD_SOLVE, 0, 0, '0);

    // Random phases: no idling, heavy idling, light idling
    base = queued_requests;
    phase = -1;
    while (queued_requests < 350) begin
      if ((queued_requests - base) * 3 / (350 - base) != phase) begin
        phase = (queued_requests - base) * 3 / (350 - base);
        push_pace(phase == 1 ? 47 : phase == 2 ? 21 : 0);
      end
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      push_register(REG_ROWS, 47'(n));
      push_register(REG_LIMIT, 47'($urandom_range(1, 30)));
      push_register(REG_THRESHOLD, pick_threshold());
      load_system(n);
      // Noise: stray loads anywhere, including the live region
      repeat ($urandom_range(0, 3))
        push_request(cmd_t'($urandom_range(0, 2)), $urandom_range(0, 63),
                     $urandom_range(0, 63), {$urandom(), $urandom()});
      push_request(CMD_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63),
                   {$urandom(), $urandom()});
      if ($urandom_range(0, 3) == 0) begin
        push_register(REG_LIMIT, 47'($urandom_range(1, 10)));
        push_request(CMD_SOLVE, 0, 0, '0);
      end
    end

    while (pending_work.size() != 0 || start || busy || solution_fifo.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
